### rtl/triangle_face_normal_defines.svh
// assertion macros shared by the checker
`ifndef TRIANGLE_FACE_NORMAL_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_DEFINES_SVH

// same-cycle implication, off during reset
`define TFN_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tfn check failed");

// next-cycle implication, off during reset
`define TFN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tfn check failed");

// checked at every edge, reset included
`define TFN_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) (cond)) \
        else $error("tfn check failed");

`endif

### rtl/tfn_pkg.sv
package tfn_pkg;

    localparam int DEF_COORD_WIDTH = 16;
    localparam int SCALE_W    = 30;          // scaled component width
    localparam int SQ_W       = 2 * SCALE_W; // one square
    localparam int SUM_W      = 63;          // sum of squares and root work width
    localparam int SQRT_STEPS = 31;          // one result bit per step
    localparam int LEN_W      = 31;
    localparam int FRAC_OUT   = 14;
    localparam int OUT_W      = 16;
    localparam int QUO_BITS   = 16;
    localparam int REM_W      = 47;

    typedef struct packed {
        logic [2:0][SCALE_W-1:0] s;
        logic [2:0]              neg;
        logic                    degen;
    } side_t;

endpackage

### rtl/tfn_sqrt_pipe.sv
module tfn_sqrt_pipe
    import tfn_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  logic [SUM_W-1:0] in_sum,
    input  side_t            in_side,
    output logic             out_vld,
    output logic [LEN_W-1:0] out_len,
    output side_t            out_side
);

    logic [SUM_W-1:0] v_reg    [SQRT_STEPS];
    logic [SUM_W-1:0] r_reg    [SQRT_STEPS];
    side_t            side_reg [SQRT_STEPS];
    logic             vld_reg  [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (SQRT_STEPS - 1 - k));
        logic [SUM_W-1:0] v_in;
        logic [SUM_W-1:0] r_in;
        logic [SUM_W-1:0] t;
        logic [SUM_W-1:0] v_next;
        logic [SUM_W-1:0] r_next;
        side_t            side_in;
        logic             vld_in;

        if (k == 0) begin : g_first
            assign v_in    = in_sum;
            assign r_in    = '0;
            assign side_in = in_side;
            assign vld_in  = in_vld;
        end
        else begin : g_rest
            assign v_in    = v_reg[k-1];
            assign r_in    = r_reg[k-1];
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        // one digit of the restoring root
        always_comb
        begin
            t = r_in + BIT;
            if (v_in >= t)
            begin
                v_next = v_in - t;
                r_next = (r_in >> 1) + BIT;
            end
            else
            begin
                v_next = v_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k]    <= v_next;
                r_reg[k]    <= r_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_vld  = vld_reg[SQRT_STEPS-1];
    assign out_len  = r_reg[SQRT_STEPS-1][LEN_W-1:0];
    assign out_side = side_reg[SQRT_STEPS-1];

endmodule

### rtl/tfn_div_pipe.sv
module tfn_div_pipe
    import tfn_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_vld,
    input  logic [LEN_W-1:0]        in_len,
    input  side_t                   in_side,
    output logic                    out_vld,
    output logic [2:0][QUO_BITS-1:0] out_q,
    output side_t                   out_side
);

    logic [REM_W-1:0]    rem_reg  [QUO_BITS][3];
    logic [QUO_BITS-1:0] q_reg    [QUO_BITS][3];
    logic [LEN_W-1:0]    len_reg  [QUO_BITS];
    side_t               side_reg [QUO_BITS];
    logic                vld_reg  [QUO_BITS];

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
        logic [LEN_W-1:0]    len_in;
        logic [REM_W-1:0]    rem_in [3];
        logic [QUO_BITS-1:0] q_in   [3];
        logic [REM_W-1:0]    dsh;
        logic [REM_W-1:0]    rem_next [3];
        logic [QUO_BITS-1:0] q_next   [3];
        side_t               side_in;
        logic                vld_in;

        if (k == 0) begin : g_first
            // numerator with half the divisor added for rounding
            assign len_in = (in_len == '0) ? LEN_W'(1) : in_len;
            for (genvar c = 0; c < 3; c++) begin : g_num
                assign rem_in[c] = (REM_W'(in_side.s[c]) << FRAC_OUT)
                                   + REM_W'(len_in >> 1);
                assign q_in[c]   = '0;
            end
            assign side_in = in_side;
            assign vld_in  = in_vld;
        end
        else begin : g_rest
            assign len_in = len_reg[k-1];
            for (genvar c = 0; c < 3; c++) begin : g_prev
                assign rem_in[c] = rem_reg[k-1][c];
                assign q_in[c]   = q_reg[k-1][c];
            end
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        assign dsh = REM_W'(len_in) << (QUO_BITS - 1 - k);

        always_comb
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (rem_in[c] >= dsh)
                begin
                    rem_next[c] = rem_in[c] - dsh;
                    q_next[c]   = q_in[c] | (QUO_BITS'(1) << (QUO_BITS - 1 - k));
                end
                else
                begin
                    rem_next[c] = rem_in[c];
                    q_next[c]   = q_in[c];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    rem_reg[k][c] <= rem_next[c];
                    q_reg[k][c]   <= q_next[c];
                end
                len_reg[k]  <= len_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_vld  = vld_reg[QUO_BITS-1];
    assign out_side = side_reg[QUO_BITS-1];
    for (genvar c = 0; c < 3; c++) begin : g_out
        assign out_q[c] = q_reg[QUO_BITS-1][c];
    end

endmodule

### rtl/triangle_face_normal.sv
// triangle unit face normal
// input channel: in_valid / in_stall with the nine vertex coordinates (signed
//   Q8.8, COORD_WIDTH bits); an item is taken when in_valid is high and
//   in_stall is low
// output channel: out_valid / out_stall with normal_x/y/z (signed Q1.14) and
//   degenerate; a zero cross product gives a zero normal with degenerate set
// pipeline: 56 register stages (8 front stages, 31 root steps, 16 quotient steps,
//   one output register)
// throughput: one item per cycle while not stalled; every stage is a register,
//   so a new triangle enters each unstalled cycle; valid bits travel with the data
// stall: the whole pipeline holds while the output register is full and
//   out_stall is high; in_stall then rises so nothing is lost or repeated
// reset: rst_n clears all valid bits at once; no item is in flight afterward
//   and the block is ready in the first cycle after release
module triangle_face_normal
    import tfn_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] first_x,
    input  logic signed [COORD_WIDTH-1:0] first_y,
    input  logic signed [COORD_WIDTH-1:0] first_z,
    input  logic signed [COORD_WIDTH-1:0] second_x,
    input  logic signed [COORD_WIDTH-1:0] second_y,
    input  logic signed [COORD_WIDTH-1:0] second_z,
    input  logic signed [COORD_WIDTH-1:0] third_x,
    input  logic signed [COORD_WIDTH-1:0] third_y,
    input  logic signed [COORD_WIDTH-1:0] third_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [OUT_W-1:0]       normal_x,
    output logic signed [OUT_W-1:0]       normal_y,
    output logic signed [OUT_W-1:0]       normal_z,
    output logic                          degenerate
);

    localparam int DW = COORD_WIDTH + 1;   // edge component
    localparam int PW = 2 * DW;            // product
    localparam int XW = PW + 1;            // cross component
    localparam int MW = XW;                // cross magnitude
    localparam int TW = $clog2(MW + 1);    // bit count of a magnitude

    // output register valid bit
    logic out_valid_reg;

    // pipeline moves whenever the output register can take a new item
    logic en;
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // stage 1: edge vectors
    logic signed [DW-1:0] a_reg [3];
    logic signed [DW-1:0] b_reg [3];
    logic                 v1_reg;
    logic signed [DW-1:0] a_next [3];
    logic signed [DW-1:0] b_next [3];

    assign a_next[0] = DW'(first_x) - DW'(second_x);
    assign a_next[1] = DW'(first_y) - DW'(second_y);
    assign a_next[2] = DW'(first_z) - DW'(second_z);
    assign b_next[0] = DW'(first_x) - DW'(third_x);
    assign b_next[1] = DW'(first_y) - DW'(third_y);
    assign b_next[2] = DW'(first_z) - DW'(third_z);

    // stage 2: six products of the cross product
    logic signed [PW-1:0] p_reg [6];
    logic                 v2_reg;

    // stage 3: cross components
    logic signed [XW-1:0] c_reg [3];
    logic                 v3_reg;

    // stage 4: magnitudes and signs
    logic [MW-1:0] m_reg [3];
    logic [2:0]    neg4_reg;
    logic [MW-1:0] orw_reg;
    logic          v4_reg;

    // stage 5: bit count of the largest magnitude
    logic [MW-1:0] m5_reg [3];
    logic [2:0]    neg5_reg;
    logic [TW-1:0] top_reg;
    logic          degen5_reg;
    logic          v5_reg;
    logic [TW-1:0] top_next;

    always_comb
    begin
        top_next = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (orw_reg[i])
                top_next = TW'(i + 1);
        end
    end

    // stage 6: normalize so the largest lies in [2^29, 2^30)
    side_t                     side6_reg;
    logic                      v6_reg;
    logic [MW+SCALE_W-1:0]     wsh [3];
    side_t                     side6_next;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            wsh[c]          = {m5_reg[c], SCALE_W'(0)} >> top_reg;
            side6_next.s[c] = wsh[c][SCALE_W-1:0];
        end
        side6_next.neg   = neg5_reg;
        side6_next.degen = degen5_reg;
    end

    // stage 7: squares
    logic [SQ_W-1:0] sq_reg [3];
    side_t           side7_reg;
    logic            v7_reg;

    // stage 8: sum of squares
    logic [SUM_W-1:0] sum_reg;
    side_t            side8_reg;
    logic             v8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                a_reg[c] <= a_next[c];
                b_reg[c] <= b_next[c];
            end

            p_reg[0] <= a_reg[1] * b_reg[2];
            p_reg[1] <= b_reg[1] * a_reg[2];
            p_reg[2] <= b_reg[0] * a_reg[2];
            p_reg[3] <= a_reg[0] * b_reg[2];
            p_reg[4] <= a_reg[0] * b_reg[1];
            p_reg[5] <= b_reg[0] * a_reg[1];

            for (int c = 0; c < 3; c++)
                c_reg[c] <= XW'(p_reg[2*c]) - XW'(p_reg[2*c+1]);

            for (int c = 0; c < 3; c++)
            begin
                m_reg[c]    <= c_reg[c][XW-1] ? MW'(-c_reg[c]) : MW'(c_reg[c]);
                neg4_reg[c] <= c_reg[c][XW-1];
            end
            // or of the magnitudes, so its top bit is that of the largest
            orw_reg <= MW'(c_reg[0][XW-1] ? -c_reg[0] : c_reg[0])
                     | MW'(c_reg[1][XW-1] ? -c_reg[1] : c_reg[1])
                     | MW'(c_reg[2][XW-1] ? -c_reg[2] : c_reg[2]);

            for (int c = 0; c < 3; c++)
                m5_reg[c] <= m_reg[c];
            neg5_reg   <= neg4_reg;
            top_reg    <= top_next;
            degen5_reg <= (orw_reg == '0);

            side6_reg <= side6_next;

            for (int c = 0; c < 3; c++)
                sq_reg[c] <= SQ_W'(side6_reg.s[c]) * SQ_W'(side6_reg.s[c]);
            side7_reg <= side6_reg;

            sum_reg   <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            side8_reg <= side7_reg;
        end
    end

    // length: pipelined integer square root, one bit per stage
    logic             sq_vld;
    logic [LEN_W-1:0] sq_len;
    side_t            sq_side;

    tfn_sqrt_pipe u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v8_reg),
        .in_sum   (sum_reg),
        .in_side  (side8_reg),
        .out_vld  (sq_vld),
        .out_len  (sq_len),
        .out_side (sq_side)
    );

    // three rounded quotients, one bit per stage
    logic                     dv_vld;
    logic [2:0][QUO_BITS-1:0] dv_q;
    side_t                    dv_side;

    tfn_div_pipe u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (sq_vld),
        .in_len   (sq_len),
        .in_side  (sq_side),
        .out_vld  (dv_vld),
        .out_q    (dv_q),
        .out_side (dv_side)
    );

    // output register: clamp to one, reapply sign, zero on degenerate
    localparam logic [QUO_BITS-1:0] ONE_Q = QUO_BITS'(1) << FRAC_OUT;

    logic [2:0][OUT_W-1:0]   n_reg;
    logic                    degen_reg;
    logic [2:0][OUT_W-1:0]   n_next;
    logic [QUO_BITS-1:0]     clamp [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            clamp[c] = (dv_q[c] > ONE_Q) ? ONE_Q : dv_q[c];
            if (dv_side.degen)
                n_next[c] = '0;
            else if (dv_side.neg[c])
                n_next[c] = OUT_W'(-clamp[c]);
            else
                n_next[c] = OUT_W'(clamp[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg     <= n_next;
            degen_reg <= dv_side.degen;
        end
    end

    assign out_valid  = out_valid_reg;
    assign normal_x   = n_reg[0];
    assign normal_y   = n_reg[1];
    assign normal_z   = n_reg[2];
    assign degenerate = degen_reg;

endmodule

### rtl/tfn_checker.sv
`include "triangle_face_normal_defines.svh"

module tfn_checker
    import tfn_pkg::*;
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [OUT_W-1:0]       normal_x,
    input logic signed [OUT_W-1:0]       normal_y,
    input logic signed [OUT_W-1:0]       normal_z,
    input logic                          degenerate
);

    localparam logic signed [OUT_W-1:0] ONE_P = OUT_W'(16384);
    localparam logic signed [OUT_W-1:0] ONE_N = -OUT_W'(16384);

    // a waiting item stays until taken
    `TFN_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid)

    // degenerate items carry a zero normal
    `TFN_ASSERT_NOW(a_degen_zero, out_valid && degenerate,
        normal_x == '0 && normal_y == '0 && normal_z == '0)

    // components stay within plus or minus one
    `TFN_ASSERT_NOW(a_range, out_valid,
        normal_x <= ONE_P && normal_x >= ONE_N && normal_y <= ONE_P &&
        normal_y >= ONE_N && normal_z <= ONE_P && normal_z >= ONE_N)

    // input is held off only while the output is full and stalled
    `TFN_ASSERT_NOW(a_backpressure, 1'b1, in_stall == (out_valid && out_stall))

    // nothing leaves while in reset
    `TFN_ASSERT_ALWAYS(a_reset, rst_n || !out_valid)

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .normal_x   (normal_x),
    .normal_y   (normal_y),
    .normal_z   (normal_z),
    .degenerate (degenerate)
);

### verif/triangle_face_normal_test.sv
`timescale 1ns / 1ps

module triangle_face_normal_test;
    import tfn_pkg::*;

    localparam int CW = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 80;

    // one triangle as driven on the input ports
    typedef struct packed {
        logic signed [CW-1:0] fx, fy, fz;
        logic signed [CW-1:0] sx, sy, sz;
        logic signed [CW-1:0] tx, ty, tz;
    } triangle_t;

    // one expected unit normal
    typedef struct packed {
        logic signed [OUT_W-1:0] nx, ny, nz;
        logic                    degen;
    } face_normal_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic signed [CW-1:0]          first_x, first_y, first_z;
    logic signed [CW-1:0]          second_x, second_y, second_z;
    logic signed [CW-1:0]          third_x, third_y, third_z;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [OUT_W-1:0]       normal_x, normal_y, normal_z;
    logic                          degenerate;

    // normals still owed by the block, oldest first
    face_normal_t pending_normals[$];

    int  sender_idle_pct;
    int  receiver_stall_pct;
    int  hold_off_left;     // cycles the receiver still refuses every item
    int  error_count;
    int  triangles_sent;
    int  normals_checked;
    int  degenerate_seen;
    int  quiet_cycles;

    triangle_face_normal #(.COORD_WIDTH(CW)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .first_x   (first_x),
        .first_y   (first_y),
        .first_z   (first_z),
        .second_x  (second_x),
        .second_y  (second_y),
        .second_z  (second_z),
        .third_x   (third_x),
        .third_y   (third_y),
        .third_z   (third_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .normal_x  (normal_x),
        .normal_y  (normal_y),
        .normal_z  (normal_z),
        .degenerate(degenerate)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // bitwise integer square root, floor
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitpos;
        root = 64'd0;
        bitpos = 64'd1 << 62;
        while (bitpos > v)
            bitpos = bitpos >> 2;
        while (bitpos != 0)
        begin
            if (v >= root + bitpos)
            begin
                v = v - (root + bitpos);
                root = (root >> 1) + bitpos;
            end
            else
                root = root >> 1;
            bitpos = bitpos >> 2;
        end
        return root;
    endfunction

    // unit normal of (first - second) x (first - third), Q1.14, rounded half away from zero
    function automatic face_normal_t predict_normal(input triangle_t t);
        face_normal_t res;
        longint       ea[3], eb[3], cr[3];
        logic [63:0]  mag[3], sc[3], sum, len, q;
        int           top, nb, shift, i;
        ea[0] = longint'(t.fx) - longint'(t.sx);
        ea[1] = longint'(t.fy) - longint'(t.sy);
        ea[2] = longint'(t.fz) - longint'(t.sz);
        eb[0] = longint'(t.fx) - longint'(t.tx);
        eb[1] = longint'(t.fy) - longint'(t.ty);
        eb[2] = longint'(t.fz) - longint'(t.tz);
        cr[0] = ea[1] * eb[2] - eb[1] * ea[2];
        cr[1] = eb[0] * ea[2] - ea[0] * eb[2];
        cr[2] = ea[0] * eb[1] - eb[0] * ea[1];
        top = 0;
        for (i = 0; i < 3; i++)
        begin
            mag[i] = (cr[i] < 0) ? 64'(-cr[i]) : 64'(cr[i]);
            nb = 0;
            while ((mag[i] >> nb) != 0)
                nb++;
            if (nb > top)
                top = nb;
        end
        res = '0;
        if (top == 0)
        begin
            res.degen = 1'b1;
            return res;
        end
        // bring the largest component into [2^29, 2^30)
        shift = top - 30;
        sum = 64'd0;
        for (i = 0; i < 3; i++)
        begin
            sc[i] = (shift >= 0) ? (mag[i] >> shift) : (mag[i] << (-shift));
            sum = sum + sc[i] * sc[i];
        end
        len = floor_sqrt(sum);
        if (len == 0)
            len = 64'd1;
        for (i = 0; i < 3; i++)
        begin
            q = ((sc[i] << FRAC_OUT) + (len >> 1)) / len;
            if (q > (64'd1 << FRAC_OUT))
                q = 64'd1 << FRAC_OUT;
            if (cr[i] < 0)
                q = -q;
            case (i)
                0: res.nx = q[OUT_W-1:0];
                1: res.ny = q[OUT_W-1:0];
                default: res.nz = q[OUT_W-1:0];
            endcase
        end
        return res;
    endfunction

    // offer one triangle, idling first at the sender's rate, and hold it until taken
    task automatic send_triangle(input triangle_t t);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        first_x  <= t.fx;
        first_y  <= t.fy;
        first_z  <= t.fz;
        second_x <= t.sx;
        second_y <= t.sy;
        second_z <= t.sz;
        third_x  <= t.tx;
        third_y  <= t.ty;
        third_z  <= t.tz;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_normals.insert(pending_normals.size(), predict_normal(t));
        triangles_sent++;
        @(negedge clk);
    endtask

    task automatic go_quiet();
        in_valid <= 1'b0;
        wait (pending_normals.size() == 0);
        @(negedge clk);
    endtask

    function automatic triangle_t make_triangle(
        input int fx, input int fy, input int fz,
        input int sx, input int sy, input int sz,
        input int tx, input int ty, input int tz);
        triangle_t t;
        t.fx = CW'(fx); t.fy = CW'(fy); t.fz = CW'(fz);
        t.sx = CW'(sx); t.sy = CW'(sy); t.sz = CW'(sz);
        t.tx = CW'(tx); t.ty = CW'(ty); t.tz = CW'(tz);
        return t;
    endfunction

    // any 16-bit coordinate, biased toward the extremes now and then
    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return CW'($urandom_range(16) - 8);
            default: return CW'($urandom);
        endcase
    endfunction

    // mixes full range, small triangles, and collinear or coincident vertices
    function automatic triangle_t rand_triangle();
        triangle_t t;
        int        k, dx, dy, dz;
        t.fx = rand_coord(); t.fy = rand_coord(); t.fz = rand_coord();
        t.sx = rand_coord(); t.sy = rand_coord(); t.sz = rand_coord();
        t.tx = rand_coord(); t.ty = rand_coord(); t.tz = rand_coord();
        case ($urandom_range(9))
            0:
            begin
                // third vertex on the line through first and second
                dx = $urandom_range(64) - 32;
                dy = $urandom_range(64) - 32;
                dz = $urandom_range(64) - 32;
                k = $urandom_range(6) - 3;
                t.sx = CW'(t.fx + dx); t.sy = CW'(t.fy + dy); t.sz = CW'(t.fz + dz);
                t.tx = CW'(t.fx + k * dx);
                t.ty = CW'(t.fy + k * dy);
                t.tz = CW'(t.fz + k * dz);
            end
            1:
            begin
                // two vertices coincide
                t.tx = t.sx; t.ty = t.sy; t.tz = t.sz;
            end
            2, 3:
            begin
                // small triangle near the first vertex
                t.sx = t.fx + CW'($urandom_range(8) - 4);
                t.sy = t.fy + CW'($urandom_range(8) - 4);
                t.sz = t.fz + CW'($urandom_range(8) - 4);
                t.tx = t.fx + CW'($urandom_range(8) - 4);
                t.ty = t.fy + CW'($urandom_range(8) - 4);
                t.tz = t.fz + CW'($urandom_range(8) - 4);
            end
            default: ;
        endcase
        return t;
    endfunction

    // receiver: stalls at its own rate, or for a counted hold-off stretch
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off_left > 0)
        begin
            out_stall <= 1'b1;
            hold_off_left <= hold_off_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // result checker: every taken normal against the oldest prediction
    always @(posedge clk)
    begin
        face_normal_t exp_n;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_normals.size() == 0)
            begin
                $error("normal arrived with none expected");
                error_count++;
            end
            else
            begin
                exp_n = pending_normals.pop_front();
                normals_checked++;
                if (degenerate)
                    degenerate_seen++;
                if (normal_x !== exp_n.nx)
                begin
                    $error("normal_x expected %0d got %0d", exp_n.nx, normal_x);
                    error_count++;
                end
                if (normal_y !== exp_n.ny)
                begin
                    $error("normal_y expected %0d got %0d", exp_n.ny, normal_y);
                    error_count++;
                end
                if (normal_z !== exp_n.nz)
                begin
                    $error("normal_z expected %0d got %0d", exp_n.nz, normal_z);
                    error_count++;
                end
                if (degenerate !== exp_n.degen)
                begin
                    $error("degenerate expected %0b got %0b", exp_n.degen, degenerate);
                    error_count++;
                end
            end
        end
    end

    // watchdog: cycles in a row with no item moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired, %0d normals still owed", pending_normals.size());
            $display("triangle_face_normal verification failed");
            $finish;
        end
    end

    // field extremes, axis-aligned faces and the degenerate cases
    task automatic test_directed();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        // normals along +z, -z, +x, +y
        send_triangle(make_triangle(0, 0, 0, -256, 0, 0, 0, -256, 0));
        send_triangle(make_triangle(0, 0, 0, 0, -256, 0, -256, 0, 0));
        send_triangle(make_triangle(0, 0, 0, 0, -256, 0, 0, 0, -256));
        send_triangle(make_triangle(0, 0, 0, 0, 0, -256, -256, 0, 0));
        // smallest possible face
        send_triangle(make_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0));
        // widest spans in every coordinate
        send_triangle(make_triangle(32767, 32767, 32767, -32768, 32767, -32768,
                                    -32768, -32768, 32767));
        send_triangle(make_triangle(-32768, -32768, -32768, 32767, -32768, 32767,
                                    32767, 32767, -32768));
        send_triangle(make_triangle(32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767));
        // diagonal face, equal components
        send_triangle(make_triangle(256, 0, 0, 0, 256, 0, 0, 0, 256));
        send_triangle(make_triangle(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
        // degenerate: all equal, all extremes equal, coincident pair, collinear
        send_triangle(make_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_triangle(make_triangle(32767, 32767, 32767, 32767, 32767, 32767,
                                    32767, 32767, 32767));
        send_triangle(make_triangle(-32768, -32768, -32768, -32768, -32768, -32768,
                                    -32768, -32768, -32768));
        send_triangle(make_triangle(100, 200, 300, 100, 200, 300, 7, 8, 9));
        send_triangle(make_triangle(-32768, -32768, -32768, 0, 0, 0, 32767, 32767, 32767));
        send_triangle(make_triangle(0, 0, 0, 1, 2, 3, -2, -4, -6));
        // lopsided: one long and one tiny edge
        send_triangle(make_triangle(-32768, 0, 0, 32767, 0, 0, -32768, 1, 0));
        send_triangle(make_triangle(0, 0, 0, 32767, 1, 0, 32767, 0, 1));
        go_quiet();
    endtask

    // random triangles under one idling pattern
    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (count)
            send_triangle(rand_triangle());
        go_quiet();
    endtask

    // receiver holds off long enough that the pipeline fills and stalls its input
    task automatic test_backpressure();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_off_left = 200;
        repeat (120)
            send_triangle(rand_triangle());
        go_quiet();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        {first_x, first_y, first_z} = '0;
        {second_x, second_y, second_z} = '0;
        {third_x, third_y, third_z} = '0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_off_left = 0;
        error_count = 0;
        triangles_sent = 0;
        normals_checked = 0;
        degenerate_seen = 0;
        quiet_cycles = 0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(180, 0, 0);
        test_random(140, 71, 0);
        test_random(140, 0, 71);
        test_random(140, 10, 10);
        test_backpressure();

        // let anything unexpected still in flight show up
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("%0d triangles sent, %0d normals checked, %0d degenerate",
                 triangles_sent, normals_checked, degenerate_seen);
        $display("phases: directed, back to back, idle sender, stalling receiver, both, long hold-off");
        if (error_count == 0 && pending_normals.size() == 0)
            $display("triangle_face_normal verification clean");
        else
            $display("triangle_face_normal verification failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/tfn_pkg.sv
rtl/tfn_sqrt_pipe.sv
rtl/tfn_div_pipe.sv
rtl/triangle_face_normal.sv
rtl/tfn_checker.sv
verif/triangle_face_normal_test.sv
